// ===== src/hpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hpt_pkg;

	// Width of every coordinate and matrix element.
	localparam int unsigned DATA_W = 32;
	localparam int unsigned REG_W  = 64;
	localparam int unsigned IDX_W  = 3;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
	localparam logic [IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
	localparam logic [IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
	localparam logic [IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
	localparam logic [IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
	localparam logic [IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

	// Input mode codes.
	localparam logic ACT_PROJECT     = 1'b0;
	localparam logic ACT_HOMOGENEOUS = 1'b1;

	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

	// Stage counts of the datapath.
	localparam int unsigned MAC_LAT = 3;
	localparam int unsigned QUO_W   = 31;
	localparam int unsigned DIV_LAT = QUO_W + 2;

	// Data that rides beside the dividers.
	typedef struct packed {
		logic                      action;
		logic signed [DATA_W-1:0] sum_x;
		logic signed [DATA_W-1:0] sum_y;
		logic signed [DATA_W-1:0] sum_z;
		logic signed [DATA_W-1:0] sum_w;
	} side_t;

endpackage
`default_nettype wire

// ===== src/hpt_col.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hpt_col #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire                                   clk,
	input  wire                                   ce,
	input  wire  signed [hpt_pkg::DATA_W-1:0]     px,
	input  wire  signed [hpt_pkg::DATA_W-1:0]     py,
	input  wire  signed [hpt_pkg::DATA_W-1:0]     pz,
	input  wire  signed [hpt_pkg::DATA_W-1:0]     m0,
	input  wire  signed [hpt_pkg::DATA_W-1:0]     m1,
	input  wire  signed [hpt_pkg::DATA_W-1:0]     m2,
	input  wire  signed [hpt_pkg::DATA_W-1:0]     m3,
	output logic signed [hpt_pkg::DATA_W-1:0]     sum
);

	localparam int unsigned PW = 2 * hpt_pkg::DATA_W;
	localparam int unsigned SW = PW + 3;

	logic signed [PW-1:0] p0_s1, p1_s1, p2_s1;
	logic signed [hpt_pkg::DATA_W-1:0] m3_s1;
	logic signed [SW-1:0] a_s2, b_s2;
	logic signed [SW-1:0] rnd;
	logic signed [SW-1:0] tot;
	logic signed [SW-1:0] shf;

	// Stage 1: the three products.
	always_ff @(posedge clk) begin
		if (ce) begin
			p0_s1 <= PW'(px) * PW'(m0);
			p1_s1 <= PW'(py) * PW'(m1);
			p2_s1 <= PW'(pz) * PW'(m2);
			m3_s1 <= m3;
		end
	end

	// Stage 2: two partial sums; the rounding half and the scaled translation join here.
	assign rnd = SW'(1) <<< (FRAC_BITS - 1);
	always_ff @(posedge clk) begin
		if (ce) begin
			a_s2 <= SW'(p0_s1) + SW'(p1_s1);
			b_s2 <= SW'(p2_s1) + (SW'(m3_s1) <<< FRAC_BITS) + rnd;
		end
	end

	// Stage 3: final sum, floor by the fraction width, saturate.
	assign tot = a_s2 + b_s2;
	assign shf = tot >>> FRAC_BITS;
	always_ff @(posedge clk) begin
		if (ce) begin
			if (shf > SW'(hpt_pkg::Q_MAX)) begin
				sum <= hpt_pkg::Q_MAX;
			end else if (shf < SW'(hpt_pkg::Q_MIN)) begin
				sum <= hpt_pkg::Q_MIN;
			end else begin
				sum <= shf[hpt_pkg::DATA_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/hpt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hpt_div #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire                                   clk,
	input  wire                                   ce,
	input  wire  signed [hpt_pkg::DATA_W-1:0]     num,
	input  wire  signed [hpt_pkg::DATA_W-1:0]     den,
	output logic signed [hpt_pkg::DATA_W-1:0]     quo
);

	localparam int unsigned DW = hpt_pkg::DATA_W;
	localparam int unsigned QW = hpt_pkg::QUO_W;
	localparam int unsigned NW = DW + FRAC_BITS + 1;
	localparam int unsigned CW = DW + QW;

	logic [DW-1:0] n_mag, d_mag;
	logic [NW-1:0] n_ext;

	logic [NW-1:0] rem_s [QW+1];
	logic [QW-1:0] q_s   [QW+1];
	logic [DW-1:0] ud_s  [QW+1];
	logic          neg_s [QW+1];
	logic          ovf_s [QW+1];
	logic [DW-1:0] qmag;

	// Setup stage: magnitudes, rounded numerator, overflow check.
	assign n_mag = num[DW-1] ? DW'(-num) : DW'(num);
	assign d_mag = den[DW-1] ? DW'(-den) : DW'(den);
	assign n_ext = (NW'(n_mag) << FRAC_BITS) + NW'(d_mag >> 1);

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s[0] <= n_ext;
			q_s[0]   <= '0;
			ud_s[0]  <= d_mag;
			neg_s[0] <= num[DW-1] ^ den[DW-1];
			ovf_s[0] <= CW'(n_ext) >= (CW'(d_mag) << QW);
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar i = 0; i < QW; i++) begin : g_bit
		localparam int unsigned K = QW - 1 - i;
		logic [CW-1:0] trial;
		logic          fits;
		assign trial = CW'(ud_s[i]) << K;
		assign fits  = CW'(rem_s[i]) >= trial;
		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[i+1] <= fits ? NW'(CW'(rem_s[i]) - trial) : rem_s[i];
				q_s[i+1]   <= q_s[i] | (QW'(fits) << K);
				ud_s[i+1]  <= ud_s[i];
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	// Final stage: clamp, apply the sign, saturate.
	assign qmag = ovf_s[QW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, q_s[QW]};
	always_ff @(posedge clk) begin
		if (ce) begin
			if (neg_s[QW]) begin
				quo <= -$signed(qmag);
			end else if (qmag[DW-1]) begin
				quo <= hpt_pkg::Q_MAX;
			end else begin
				quo <= $signed(qmag);
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/homogeneous_point_transform.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Transforms a point (x, y, z, 1) by a 4x4 signed fixed-point matrix held in eight
// 64-bit configuration registers (reset: identity). Each input transfer yields one
// output transfer; a new point is taken every cycle while the output is not stalled.
// Three multiply-add stages feed the restoring dividers (one quotient bit per
// stage). The whole pipeline holds while a result waits at the output.
// tuser selects project (0, divide by w) or homogeneous (1); the output tuser flags
// a zero w in project mode.
module homogeneous_point_transform #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [hpt_pkg::IDX_W-1:0]       cfg_index,
	input  wire  [hpt_pkg::REG_W-1:0]       cfg_data,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire  [95:0]                     s_tdata,  // point_x, point_y, point_z
	input  wire                             s_tuser,  // action
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [127:0]                    m_tdata,  // out_x, out_y, out_z, out_w
	output logic                            m_tuser   // divide_fault
);

	localparam int unsigned DW  = hpt_pkg::DATA_W;
	localparam int unsigned LAT = hpt_pkg::MAC_LAT + hpt_pkg::DIV_LAT + 1;
	localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

	logic [hpt_pkg::REG_W-1:0] mat_q [8];
	logic signed [DW-1:0] m [4][4];
	logic signed [DW-1:0] sum [4];
	logic signed [DW-1:0] quo [3];
	logic                 act_s1, act_s2, act_s3;
	hpt_pkg::side_t       side_s [hpt_pkg::DIV_LAT];
	logic [LAT-1:0]       vld_s;
	logic                 ce;
	logic                 fault;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[hpt_pkg::REG_ROW0_COLS01] <= {32'd0, ONE};
			mat_q[hpt_pkg::REG_ROW0_COLS23] <= '0;
			mat_q[hpt_pkg::REG_ROW1_COLS01] <= {ONE, 32'd0};
			mat_q[hpt_pkg::REG_ROW1_COLS23] <= '0;
			mat_q[hpt_pkg::REG_ROW2_COLS01] <= '0;
			mat_q[hpt_pkg::REG_ROW2_COLS23] <= {32'd0, ONE};
			mat_q[hpt_pkg::REG_ROW3_COLS01] <= '0;
			mat_q[hpt_pkg::REG_ROW3_COLS23] <= {ONE, 32'd0};
		end else if (cfg_we) begin
			mat_q[cfg_index] <= cfg_data;
		end
	end

	// Matrix elements: row r, even column low half, odd column high half.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			m[r][0] = mat_q[2*r][31:0];
			m[r][1] = mat_q[2*r][63:32];
			m[r][2] = mat_q[2*r+1][31:0];
			m[r][3] = mat_q[2*r+1][63:32];
		end
	end

	// The pipeline moves whenever the output slot is free or being emptied.
	assign ce       = !m_tvalid || m_tready;
	assign s_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[LAT-2:0], s_tvalid};
		end
	end
	assign m_tvalid = vld_s[LAT-1];

	// Four column sums.
	for (genvar c = 0; c < 4; c++) begin : g_col
		hpt_col #(.FRAC_BITS(FRAC_BITS)) u_col (
			.clk (clk),
			.ce  (ce),
			.px  (s_tdata[31:0]),
			.py  (s_tdata[63:32]),
			.pz  (s_tdata[95:64]),
			.m0  (m[0][c]),
			.m1  (m[1][c]),
			.m2  (m[2][c]),
			.m3  (m[3][c]),
			.sum (sum[c])
		);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			act_s1 <= s_tuser;
			act_s2 <= act_s1;
			act_s3 <= act_s2;
		end
	end

	// Three dividers by w.
	for (genvar c = 0; c < 3; c++) begin : g_div
		hpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk (clk),
			.ce  (ce),
			.num (sum[c]),
			.den (sum[3]),
			.quo (quo[c])
		);
	end

	// Mode and sums travel beside the dividers.
	always_ff @(posedge clk) begin
		if (ce) begin
			side_s[0] <= '{action: act_s3, sum_x: sum[0], sum_y: sum[1],
				sum_z: sum[2], sum_w: sum[3]};
			for (int i = 1; i < hpt_pkg::DIV_LAT; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// Output stage: pick sums, quotients or the zero-w result.
	assign fault = (side_s[hpt_pkg::DIV_LAT-1].action == hpt_pkg::ACT_PROJECT) &&
		(side_s[hpt_pkg::DIV_LAT-1].sum_w == '0);

	always_ff @(posedge clk) begin
		if (ce) begin
			m_tuser <= fault;
			if (side_s[hpt_pkg::DIV_LAT-1].action == hpt_pkg::ACT_HOMOGENEOUS) begin
				m_tdata <= {side_s[hpt_pkg::DIV_LAT-1].sum_w, side_s[hpt_pkg::DIV_LAT-1].sum_z,
					side_s[hpt_pkg::DIV_LAT-1].sum_y, side_s[hpt_pkg::DIV_LAT-1].sum_x};
			end else if (fault) begin
				m_tdata <= {32'd0,
					side_s[hpt_pkg::DIV_LAT-1].sum_z[DW-1] ? hpt_pkg::Q_MIN : hpt_pkg::Q_MAX,
					side_s[hpt_pkg::DIV_LAT-1].sum_y[DW-1] ? hpt_pkg::Q_MIN : hpt_pkg::Q_MAX,
					side_s[hpt_pkg::DIV_LAT-1].sum_x[DW-1] ? hpt_pkg::Q_MIN : hpt_pkg::Q_MAX};
			end else begin
				m_tdata <= {side_s[hpt_pkg::DIV_LAT-1].sum_w, quo[2], quo[1], quo[0]};
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/hpt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hpt_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         s_tready,
	input wire         m_tvalid,
	input wire         m_tready,
	input wire [127:0] m_tdata,
	input wire         m_tuser
);

	// A result held at the output keeps its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	// A stalled output stops input transfers.
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	// A divide fault always reports w as zero.
	a_fault_w: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[127:96] == 32'd0)
		else $error("fault with nonzero w");

	// A free output slot never blocks the input.
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

	localparam int FRAC = 16;
	localparam int PIPE_LAT = 37;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
		logic               fault;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [hpt_pkg::IDX_W-1:0] cfg_index = '0;
	logic [hpt_pkg::REG_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [95:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic m_tuser;

	// Shadow copy of the matrix registers.
	logic [hpt_pkg::REG_W-1:0] matrix_regs [8];
	vertex_t expected_vertices [$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;
	int errors = 0;
	int points_sent = 0;
	int vertices_checked = 0;
	int faults_seen = 0;
	int quiet_cycles = 0;

	homogeneous_point_transform #(.FRAC_BITS(FRAC)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint matrix_elem(int r, int c);
		logic [hpt_pkg::REG_W-1:0] word;
		logic signed [31:0] half;
		word = matrix_regs[r * 2 + c / 2];
		half = (c % 2) ? word[63:32] : word[31:0];
		return longint'(half);
	endfunction

	function automatic longint saturate32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Exact dot product with one column, rounded half up, then saturated.
	function automatic longint column_dot(longint px, longint py, longint pz, int c);
		logic signed [95:0] acc;
		acc = (96'(signed'(matrix_elem(3, c))) <<< FRAC)
			+ 96'(signed'(px)) * 96'(signed'(matrix_elem(0, c)))
			+ 96'(signed'(py)) * 96'(signed'(matrix_elem(1, c)))
			+ 96'(signed'(pz)) * 96'(signed'(matrix_elem(2, c)))
			+ (96'sd1 <<< (FRAC - 1));
		acc = acc >>> FRAC;
		if (acc > 96'sd2147483647) return 64'sd2147483647;
		if (acc < -96'sd2147483648) return -64'sd2147483648;
		return longint'(acc);
	endfunction

	// Quotient rounded to nearest, ties away from zero.
	function automatic longint round_divide(longint n, longint d);
		logic [63:0] un, ud, q;
		bit neg;
		neg = (n < 0) != (d < 0);
		un = (n < 0 ? -n : n);
		un = un << FRAC;
		ud = (d < 0 ? -d : d);
		q = (un + (ud >> 1)) / ud;
		if (q > 64'h8000_0000) q = 64'h8000_0000;
		return saturate32(neg ? -longint'(q) : longint'(q));
	endfunction

	function automatic vertex_t transform_point(logic action, logic [95:0] pt);
		longint px, py, pz;
		longint sums [4];
		vertex_t v;
		px = longint'(signed'(pt[31:0]));
		py = longint'(signed'(pt[63:32]));
		pz = longint'(signed'(pt[95:64]));
		for (int c = 0; c < 4; c++) sums[c] = column_dot(px, py, pz, c);
		v.fault = 1'b0;
		v.w = 32'(sums[3]);
		if (action == hpt_pkg::ACT_HOMOGENEOUS) begin
			v.x = 32'(sums[0]); v.y = 32'(sums[1]); v.z = 32'(sums[2]);
		end else if (sums[3] == 0) begin
			v.fault = 1'b1;
			v.x = (sums[0] < 0) ? hpt_pkg::Q_MIN : hpt_pkg::Q_MAX;
			v.y = (sums[1] < 0) ? hpt_pkg::Q_MIN : hpt_pkg::Q_MAX;
			v.z = (sums[2] < 0) ? hpt_pkg::Q_MIN : hpt_pkg::Q_MAX;
		end else begin
			v.x = 32'(round_divide(sums[0], sums[3]));
			v.y = 32'(round_divide(sums[1], sums[3]));
			v.z = 32'(round_divide(sums[2], sums[3]));
		end
		return v;
	endfunction

	// Shared: send one point and record its expected vertex on transfer.
	// tvalid stays high on return so points can follow back to back;
	// wait_drained drops it at the end of a stream.
	task automatic send_point(logic action, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= action;
		s_tdata <= {z, y, x};
		do @(posedge clk); while (!s_tready);
		expected_vertices.push_back(transform_point(action, {z, y, x}));
		points_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [hpt_pkg::IDX_W-1:0] idx, logic [hpt_pkg::REG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		matrix_regs[idx] = value;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_vertices.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return hpt_pkg::Q_MAX;
			1: return hpt_pkg::Q_MIN;
			2: return 32'($urandom_range(0, 8 << FRAC)) - (32'd4 << FRAC);
			3: return 32'($signed($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(4))
			0: return hpt_pkg::Q_MAX;
			1: return hpt_pkg::Q_MIN;
			2: return 32'($urandom_range(0, 4 << FRAC)) - (32'd2 << FRAC);
			3: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_points(int count);
		for (int i = 0; i < count; i++) begin
			send_point(logic'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	// Reset identity, extremes of the fields and both modes.
	task automatic test_identity_extremes();
		send_point(hpt_pkg::ACT_PROJECT, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
		send_point(hpt_pkg::ACT_HOMOGENEOUS, hpt_pkg::Q_MAX, hpt_pkg::Q_MIN, 32'd0);
		send_point(hpt_pkg::ACT_PROJECT, hpt_pkg::Q_MAX, hpt_pkg::Q_MAX, hpt_pkg::Q_MAX);
		send_point(hpt_pkg::ACT_PROJECT, hpt_pkg::Q_MIN, hpt_pkg::Q_MIN, hpt_pkg::Q_MIN);
		send_point(hpt_pkg::ACT_HOMOGENEOUS, 32'hFFFF_FFFF, 32'd1, 32'h8000_0001);
		wait_drained();
	endtask

	// Perspective matrix with w = z, so zero z faults; also signed and saturating quotients.
	task automatic test_zero_w_and_divide();
		write_reg(hpt_pkg::REG_ROW2_COLS23, {32'h0001_0000, 32'h0001_0000});
		write_reg(hpt_pkg::REG_ROW3_COLS23, 64'd0);
		send_point(hpt_pkg::ACT_PROJECT, 32'h0003_0000, 32'hFFFD_0000, 32'd0);
		send_point(hpt_pkg::ACT_PROJECT, 32'd0, 32'd0, 32'd0);
		send_point(hpt_pkg::ACT_HOMOGENEOUS, 32'd5, 32'd7, 32'd0);
		send_point(hpt_pkg::ACT_PROJECT, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
		send_point(hpt_pkg::ACT_PROJECT, hpt_pkg::Q_MAX, hpt_pkg::Q_MIN, 32'd1);
		send_point(hpt_pkg::ACT_PROJECT, 32'h0003_0000, 32'hFFFF_8000, 32'hFFFE_0000);
		send_point(hpt_pkg::ACT_PROJECT, 32'd1, 32'd0, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	// Every register at both extremes.
	task automatic test_register_extremes();
		for (int r = 0; r < 8; r++) write_reg(hpt_pkg::IDX_W'(r), '1);
		send_point(hpt_pkg::ACT_HOMOGENEOUS, hpt_pkg::Q_MAX, hpt_pkg::Q_MIN, 32'h0001_0000);
		send_point(hpt_pkg::ACT_PROJECT, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		wait_drained();
		for (int r = 0; r < 8; r++)
			write_reg(hpt_pkg::IDX_W'(r), {hpt_pkg::Q_MIN, hpt_pkg::Q_MAX});
		send_point(hpt_pkg::ACT_HOMOGENEOUS, hpt_pkg::Q_MAX, hpt_pkg::Q_MAX, hpt_pkg::Q_MIN);
		send_point(hpt_pkg::ACT_PROJECT, 32'h0000_8000, 32'hFFFF_0000, 32'd3);
		wait_drained();
		for (int r = 0; r < 8; r++) write_reg(hpt_pkg::IDX_W'(r), 64'd0);
		send_point(hpt_pkg::ACT_PROJECT, 32'h1234_5678, 32'd9, 32'd1);
		send_point(hpt_pkg::ACT_HOMOGENEOUS, 32'd9, 32'd9, 32'd9);
		wait_drained();
	endtask

	// Random matrices in turn with each idling phase.
	task automatic test_random_phases();
		int idle_send [4] = '{0, 83, 0, 37};
		int idle_recv [4] = '{0, 0, 83, 37};
		for (int p = 0; p < 8; p++) begin
			for (int r = 0; r < 8; r++)
				write_reg(hpt_pkg::IDX_W'(r), {rand_elem(), rand_elem()});
			// In every other phase, set the w translation small but nonzero, so quotients stay in range more often.
			if (p % 2 == 0)
				write_reg(hpt_pkg::REG_ROW3_COLS23,
					{32'($urandom_range(1, 3 << FRAC)), rand_elem()});
			send_idle_pct = idle_send[p % 4];
			recv_stall_pct = idle_recv[p % 4];
			random_points(95);
			wait_drained();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// Receiver holds off long enough for the pipeline to fill and stall input.
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			random_points(60);
			begin
				int held = 0;
				while (held < 200) begin
					@(negedge clk);
					held++;
				end
				hold_off = 1'b0;
			end
		join
		wait_drained();
	endtask

	// Receiver handshake, changed at the falling edge.
	always @(negedge clk) begin
		if (hold_off) m_tready <= 1'b0;
		else m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	// Result checker and inactivity watchdog.
	always @(posedge clk) begin
		vertex_t got, want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
		if (m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96], m_tuser};
			if (expected_vertices.size() == 0) begin
				$display("%0t: unexpected vertex %h", $time, got);
				errors++;
			end else begin
				want = expected_vertices.pop_front();
				if (got.x !== want.x) $display("%0t: out_x expected %h got %h", $time, want.x, got.x);
				if (got.y !== want.y) $display("%0t: out_y expected %h got %h", $time, want.y, got.y);
				if (got.z !== want.z) $display("%0t: out_z expected %h got %h", $time, want.z, got.z);
				if (got.w !== want.w) $display("%0t: out_w expected %h got %h", $time, want.w, got.w);
				if (got.fault !== want.fault)
					$display("%0t: divide_fault expected %b got %b", $time, want.fault, got.fault);
				if (got !== want) errors++;
				if (got.fault) faults_seen++;
				vertices_checked++;
			end
		end
	end

	initial begin
		matrix_regs[0] = 64'h0000_0000_0001_0000;
		matrix_regs[1] = 64'd0;
		matrix_regs[2] = 64'h0001_0000_0000_0000;
		matrix_regs[3] = 64'd0;
		matrix_regs[4] = 64'd0;
		matrix_regs[5] = 64'h0000_0000_0001_0000;
		matrix_regs[6] = 64'd0;
		matrix_regs[7] = 64'h0001_0000_0000_0000;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_identity_extremes();
		test_zero_w_and_divide();
		test_register_extremes();
		test_random_phases();
		test_backpressure();
		// Out-of-range index is not possible on a 3-bit port; all eight are covered.
		wait_drained();
		$display("Sent %0d points and checked %0d vertices (%0d with divide fault),",
			points_sent, vertices_checked, faults_seen);
		$display("over identity, extreme and random matrices with idle and stall phases.");
		if (errors == 0 && expected_vertices.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/hpt_pkg.sv
src/hpt_col.sv
src/hpt_div.sv
src/homogeneous_point_transform.sv
src/hpt_checker.sv
tb/tb.sv
